// File: design/zsvf_pkg.sv
// Package for the trapezoidal state variable filter: widths, register
// indexes, filter modes, sequencer states, internal structs and saturation.
// Depends on nothing; every other design file imports it.
`default_nettype none

package zsvf_pkg;

   // Defaults for the top-level parameters.
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int COEF_FRAC_BITS_DEF = 24;

   // Integrator states and intermediate values are signed Q8.32.
   localparam int STATE_BITS      = 40;
   localparam int STATE_FRAC_BITS = 32;

   // Coefficient register widths.
   localparam int COEF_BITS  = 32;
   localparam int DAMP_BITS  = 27;
   localparam int NORM_BITS  = 25;
   localparam int MODE_BITS  = 2;

   // Shared multiplier: the 40-bit operand is split in two 20-bit halves.
   localparam int SPLIT_BITS   = STATE_BITS / 2;
   localparam int HI_BITS      = STATE_BITS - SPLIT_BITS;
   localparam int MUL_A_BITS   = SPLIT_BITS + 1;
   localparam int MUL_C_BITS   = COEF_BITS + 1;
   localparam int MUL_P_BITS   = MUL_A_BITS + MUL_C_BITS;
   localparam int LO_PROD_BITS = SPLIT_BITS + COEF_BITS;
   localparam int WIDE_BITS    = STATE_BITS + COEF_BITS;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FILTER_MODE = 2'd0,
      REG_COEF_G      = 2'd1,
      REG_DAMPING     = 2'd2,
      REG_NORM_H      = 2'd3
   } reg_index_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_LOWPASS  = 2'd0,
      MODE_HIGHPASS = 2'd1,
      MODE_BANDPASS = 2'd2,
      MODE_NOTCH    = 2'd3
   } mode_type;

   localparam logic [COEF_BITS-1:0] COEF_G_RESET  = 32'd109793;
   localparam logic [DAMP_BITS-1:0] DAMPING_RESET = 27'd33554432;
   localparam logic [NORM_BITS-1:0] NORM_H_RESET  = 25'd16564000;

   typedef struct packed {
      mode_type               mode;
      logic [COEF_BITS-1:0]   coef_g;
      logic [DAMP_BITS-1:0]   damping;
      logic [NORM_BITS-1:0]   norm_h;
   } cfg_type;

   typedef struct packed {
      logic                          start;
      logic signed [STATE_BITS-1:0]  operand;
      logic [COEF_BITS-1:0]          coef;
   } cmul_req_type;

   typedef struct packed {
      logic                          done;
      logic signed [STATE_BITS-1:0]  result;
   } cmul_rsp_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_LO,
      MUL_HI
   } mul_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_V3,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_UPD,
      ST_M4,
      ST_OUT
   } seq_state_type;

   // Clamp a wide signed value to the signed 40-bit state range.
   function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [WIDE_BITS-1:0] v);
      logic signed [STATE_BITS-1:0] r;
      if ((v[WIDE_BITS-1:STATE_BITS-1] == '0) || (v[WIDE_BITS-1:STATE_BITS-1] == '1)) begin
         r = v[STATE_BITS-1:0];
      end else if (v[WIDE_BITS-1]) begin
         r = {1'b1, {(STATE_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(STATE_BITS-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: design/zsvf_chan_if.sv
// Valid/ready channel interfaces for filter samples and filter results.
// Depends on zsvf_pkg for the default sample width.
`default_nettype none

interface zsvf_req_if
   import zsvf_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          restart;
   logic                          end_of_block;

   modport source (output valid, sample, restart, end_of_block, input ready);
   modport sink   (input valid, sample, restart, end_of_block, output ready);
endinterface

interface zsvf_rsp_if
   import zsvf_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] filtered;
   logic                          clipped;
   logic                          end_of_block_out;

   modport source (output valid, filtered, clipped, end_of_block_out, input ready);
   modport sink   (input valid, filtered, clipped, end_of_block_out, output ready);
endinterface

`default_nettype wire

// File: design/zsvf_cmul.sv
// Shared coefficient multiplier: 40-bit signed operand times 32-bit unsigned
// coefficient, floor shift by the coefficient fraction width, 40-bit clamp.
// Depends on zsvf_pkg.
`default_nettype none

module zsvf_cmul
   import zsvf_pkg::*;
#(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmul_req_type req,
   output cmul_rsp_type      rsp
);

   mul_state_type                  state_ff, state_in;
   logic                           done_ff, done_in;
   logic signed [HI_BITS-1:0]      a_hi_ff, a_hi_in;
   logic [COEF_BITS-1:0]           c_ff, c_in;
   logic signed [MUL_P_BITS-1:0]   prod_ff, prod_in;
   logic [LO_PROD_BITS-1:0]        acc_ff, acc_in;
   logic signed [STATE_BITS-1:0]   result_ff, result_in;

   logic signed [MUL_A_BITS-1:0]   op_a;
   logic signed [MUL_C_BITS-1:0]   op_c;
   logic signed [WIDE_BITS-1:0]    hi_wide;
   logic signed [WIDE_BITS-1:0]    lo_wide;
   logic signed [WIDE_BITS-1:0]    sum_wide;

   // The single multiplier takes the low half (as a positive value) on the
   // start cycle and the signed high half in the next cycle.
   always_comb begin
      if (state_ff == MUL_LO) begin
         op_a = MUL_A_BITS'(a_hi_ff);
         op_c = {1'b0, c_ff};
      end else begin
         op_a = {1'b0, req.operand[SPLIT_BITS-1:0]};
         op_c = {1'b0, req.coef};
      end
   end

   assign prod_in  = op_a * op_c;
   assign hi_wide  = WIDE_BITS'(prod_ff) <<< SPLIT_BITS;
   assign lo_wide  = WIDE_BITS'(acc_ff);
   assign sum_wide = hi_wide + lo_wide;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MUL_IDLE: if (req.start) state_in = MUL_LO;
         MUL_LO:   state_in = MUL_HI;
         MUL_HI:   state_in = MUL_IDLE;
         default:  state_in = MUL_IDLE;
      endcase
   end

   always_comb begin
      done_in   = 1'b0;
      a_hi_in   = a_hi_ff;
      c_in      = c_ff;
      acc_in    = acc_ff;
      result_in = result_ff;
      case (state_ff)
         MUL_IDLE: begin
            a_hi_in = req.operand[STATE_BITS-1:SPLIT_BITS];
            c_in    = req.coef;
         end
         MUL_LO: begin
            acc_in = prod_ff[LO_PROD_BITS-1:0];
         end
         MUL_HI: begin
            result_in = sat_state(sum_wide >>> COEF_FRAC_BITS);
            done_in   = 1'b1;
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_hi_ff   <= a_hi_in;
      c_ff      <= c_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule

`default_nettype wire

// File: design/zsvf_core.sv
// Sequencer and state datapath of the filter: integrators, saturating adds,
// product scheduling on the shared multiplier and output conversion.
// Depends on zsvf_pkg.
`default_nettype none

module zsvf_core
   import zsvf_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cfg_type                  cfg,
   input  wire logic                     in_fire,
   input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
   input  wire logic                     in_restart,
   input  wire logic                     in_eob,
   output logic                          in_ready,
   output cmul_req_type                  mul_req,
   input  wire cmul_rsp_type             mul_rsp,
   output logic                          res_valid,
   input  wire logic                     res_take,
   output logic signed [SAMPLE_BITS-1:0] res_filtered,
   output logic                          res_clipped,
   output logic                          res_eob
);

   localparam int SHIFT = STATE_FRAC_BITS - (SAMPLE_BITS - 1);
   localparam logic signed [STATE_BITS-1:0] SMAX =
      (STATE_BITS'(1) <<< (SAMPLE_BITS - 1)) - STATE_BITS'(1);
   localparam logic signed [STATE_BITS-1:0] SMIN = -SMAX - STATE_BITS'(1);

   seq_state_type                 state_ff, state_in;
   logic signed [STATE_BITS-1:0]  ic1_ff, ic1_in;
   logic signed [STATE_BITS-1:0]  ic2_ff, ic2_in;
   logic signed [STATE_BITS-1:0]  x_ff, x_in;
   logic signed [STATE_BITS-1:0]  v1_ff, v1_in;
   logic signed [STATE_BITS-1:0]  v2_ff, v2_in;
   logic signed [STATE_BITS-1:0]  y_ff, y_in;
   logic                          eob_ff, eob_in;

   logic signed [STATE_BITS-1:0]  p;
   logic signed [STATE_BITS-1:0]  notch_val;
   logic signed [STATE_BITS-1:0]  y_shift;
   logic                          use_damping;

   assign p           = mul_rsp.result;
   assign use_damping = (cfg.mode == MODE_HIGHPASS) || (cfg.mode == MODE_NOTCH);
   assign notch_val   = sat_state(WIDE_BITS'(x_ff) - WIDE_BITS'(p));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (in_fire) state_in = ST_V3;
         ST_V3:   state_in = ST_M1;
         ST_M1:   if (mul_rsp.done) state_in = ST_M2;
         ST_M2:   if (mul_rsp.done) state_in = ST_M3;
         ST_M3:   if (mul_rsp.done) state_in = ST_UPD;
         ST_UPD:  state_in = use_damping ? ST_M4 : ST_OUT;
         ST_M4:   if (mul_rsp.done) state_in = ST_OUT;
         ST_OUT:  if (res_take) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ic1_in          = ic1_ff;
      ic2_in          = ic2_ff;
      x_in            = x_ff;
      v1_in           = v1_ff;
      v2_in           = v2_ff;
      y_in            = y_ff;
      eob_in          = eob_ff;
      mul_req.start   = 1'b0;
      mul_req.operand = v1_ff;
      mul_req.coef    = cfg.coef_g;
      in_ready        = 1'b0;
      res_valid       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_fire) begin
               x_in   = STATE_BITS'(in_sample) <<< SHIFT;
               eob_in = in_eob;
               if (in_restart) begin
                  ic1_in = '0;
                  ic2_in = '0;
               end
            end
         end
         ST_V3: begin
            mul_req.start   = 1'b1;
            mul_req.operand = sat_state(WIDE_BITS'(x_ff) - WIDE_BITS'(ic2_ff));
            mul_req.coef    = cfg.coef_g;
         end
         ST_M1: begin
            mul_req.start   = mul_rsp.done;
            mul_req.operand = sat_state(WIDE_BITS'(ic1_ff) + WIDE_BITS'(p));
            mul_req.coef    = COEF_BITS'(cfg.norm_h);
         end
         ST_M2: begin
            mul_req.start   = mul_rsp.done;
            mul_req.operand = p;
            mul_req.coef    = cfg.coef_g;
            if (mul_rsp.done) v1_in = p;
         end
         ST_M3: begin
            if (mul_rsp.done) v2_in = sat_state(WIDE_BITS'(ic2_ff) + WIDE_BITS'(p));
         end
         ST_UPD: begin
            ic1_in = sat_state((WIDE_BITS'(v1_ff) <<< 1) - WIDE_BITS'(ic1_ff));
            ic2_in = sat_state((WIDE_BITS'(v2_ff) <<< 1) - WIDE_BITS'(ic2_ff));
            mul_req.start   = use_damping;
            mul_req.operand = v1_ff;
            mul_req.coef    = COEF_BITS'(cfg.damping);
            y_in = (cfg.mode == MODE_LOWPASS) ? v2_ff : v1_ff;
         end
         ST_M4: begin
            if (mul_rsp.done) begin
               if (cfg.mode == MODE_HIGHPASS) begin
                  y_in = sat_state(WIDE_BITS'(notch_val) - WIDE_BITS'(v2_ff));
               end else begin
                  y_in = notch_val;
               end
            end
         end
         ST_OUT: begin
            res_valid = 1'b1;
         end
         default: begin
            in_ready = 1'b0;
         end
      endcase
   end

   // Floor conversion from Q8.32 to the sample format, then clamp.
   assign y_shift = y_ff >>> SHIFT;

   always_comb begin
      res_clipped  = 1'b0;
      res_filtered = y_shift[SAMPLE_BITS-1:0];
      if (y_shift > SMAX) begin
         res_filtered = SMAX[SAMPLE_BITS-1:0];
         res_clipped  = 1'b1;
      end else if (y_shift < SMIN) begin
         res_filtered = SMIN[SAMPLE_BITS-1:0];
         res_clipped  = 1'b1;
      end
   end

   assign res_eob = eob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ic1_ff   <= '0;
         ic2_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ic1_ff   <= ic1_in;
         ic2_ff   <= ic2_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      v1_ff  <= v1_in;
      v2_ff  <= v2_in;
      y_ff   <= y_in;
      eob_ff <= eob_in;
   end

endmodule

`default_nettype wire

// File: design/zdf_state_variable_filter_top.sv
// Every coefficient product goes through the single shared multiplier, and a
// new sample is taken only after the last result has left the core.
// Reset is synchronous and active high; it clears both integrators, loads
// the register reset values and empties the output stage.
`default_nettype none

// Top level of the trapezoidal state variable filter: configuration
// registers, result output register and the core/multiplier pair.
// Depends on zsvf_pkg, zsvf_chan_if, zsvf_cmul and zsvf_core.
module zdf_state_variable_filter_top
   import zsvf_pkg::*;
#(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   zsvf_req_if.sink                       req_chan,
   zsvf_rsp_if.source                     rsp_chan,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // Configuration registers, read by the core directly without a shadow copy.
   // Software must write these only while the filter is idle; not enforced.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_FILTER_MODE: cfg_in.mode    = mode_type'(csr_wdata[MODE_BITS-1:0]);
            REG_COEF_G:      cfg_in.coef_g  = csr_wdata[COEF_BITS-1:0];
            REG_DAMPING:     cfg_in.damping = csr_wdata[DAMP_BITS-1:0];
            REG_NORM_H:      cfg_in.norm_h  = csr_wdata[NORM_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode    <= MODE_LOWPASS;
         cfg_ff.coef_g  <= COEF_G_RESET;
         cfg_ff.damping <= DAMPING_RESET;
         cfg_ff.norm_h  <= NORM_H_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input side: the core takes a sample only while its sequencer is idle.
   logic in_ready;
   logic in_fire;

   assign req_chan.ready = in_ready;
   assign in_fire        = req_chan.valid && in_ready;

   // The core and the shared multiplier it schedules.
   cmul_req_type                  mul_req;
   cmul_rsp_type                  mul_rsp;
   logic                          res_valid;
   logic                          res_take;
   logic signed [SAMPLE_BITS-1:0] res_filtered;
   logic                          res_clipped;
   logic                          res_eob;

   zsvf_core #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_fire      (in_fire),
      .in_sample    (req_chan.sample),
      .in_restart   (req_chan.restart),
      .in_eob       (req_chan.end_of_block),
      .in_ready     (in_ready),
      .mul_req      (mul_req),
      .mul_rsp      (mul_rsp),
      .res_valid    (res_valid),
      .res_take     (res_take),
      .res_filtered (res_filtered),
      .res_clipped  (res_clipped),
      .res_eob      (res_eob)
   );

   zsvf_cmul #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_cmul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   // Output register. A finished result moves here when the register is empty
   // or its current content is leaving in this cycle's transfer, which frees
   // the core to take the next sample while the consumer stalls.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] filtered_ff, filtered_in;
   logic                          clipped_ff, clipped_in;
   logic                          eob_out_ff, eob_out_in;

   assign res_take = res_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      filtered_in  = filtered_ff;
      clipped_in   = clipped_ff;
      eob_out_in   = eob_out_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         filtered_in  = res_filtered;
         clipped_in   = res_clipped;
         eob_out_in   = res_eob;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      filtered_ff <= filtered_in;
      clipped_ff  <= clipped_in;
      eob_out_ff  <= eob_out_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.filtered         = filtered_ff;
   assign rsp_chan.clipped          = clipped_ff;
   assign rsp_chan.end_of_block_out = eob_out_ff;

endmodule

`default_nettype wire
